[rtl/indexed_timer_min_heap_core_assert.svh]
// assertion macros for the indexed timer heap
`ifndef INDEXED_TIMER_MIN_HEAP_CORE_ASSERT_SVH
`define INDEXED_TIMER_MIN_HEAP_CORE_ASSERT_SVH

// same-cycle implication, clocked on clk, off while rst_n is low
`define ITMH_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on clk, off while rst_n is low
`define ITMH_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/itmh_pkg.sv]
// shared types and constants of the indexed timer heap
package itmh_pkg;

    localparam int HANDLE_W    = 6;
    localparam int NUM_HANDLES = 64;
    localparam int STATUS_W    = 3;
    localparam int OP_W        = 2;

    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 2'd0,
        OP_ADJUST = 2'd1,
        OP_DELETE = 2'd2,
        OP_TICK   = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE     = 3'd0,
        ST_EXPIRED  = 3'd1,
        ST_NONE_DUE = 3'd2,
        ST_FULL     = 3'd3,
        ST_IN_USE   = 3'd4,
        ST_ABSENT   = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOOK,
        S_LAST,
        S_SD,
        S_DNL,
        S_DNR,
        S_DMV,
        S_SU,
        S_UPW,
        S_FIN,
        S_ROOT
    } state_t;

endpackage

[rtl/itmh_if.sv]
// request and result channel interfaces of the indexed timer heap
interface itmh_in_if #(
    parameter int TIME_WIDTH = 48
);
    logic                          valid;
    logic                          ready;
    logic [itmh_pkg::OP_W-1:0]     op;
    logic [itmh_pkg::HANDLE_W-1:0] timer_handle;
    logic [TIME_WIDTH-1:0]         expire_time;
    logic [TIME_WIDTH-1:0]         now_time;

    modport source (output valid, output op, output timer_handle,
                    output expire_time, output now_time, input ready);
    modport sink   (input valid, input op, input timer_handle,
                    input expire_time, input now_time, output ready);
endinterface

interface itmh_out_if #(
    parameter int TIME_WIDTH = 48,
    parameter int CNT_W      = 7
);
    logic                          valid;
    logic                          ready;
    logic [itmh_pkg::STATUS_W-1:0] status;
    logic [itmh_pkg::HANDLE_W-1:0] expired_handle;
    logic                          last;
    logic [TIME_WIDTH-1:0]         root_expiry;
    logic                          heap_empty;
    logic [CNT_W-1:0]              timer_count;

    modport source (output valid, output status, output expired_handle, output last,
                    output root_expiry, output heap_empty, output timer_count,
                    input ready);
    modport sink   (input valid, input status, input expired_handle, input last,
                    input root_expiry, input heap_empty, input timer_count,
                    output ready);
endinterface

[rtl/itmh_ram.sv]
// single-port-write ram with one registered read port
module itmh_ram #(
    parameter int W     = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [W-1:0]             wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [W-1:0]             rdata
);

    logic [W-1:0] mem [DEPTH];
    logic [W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/indexed_timer_min_heap_core.sv]
// top level of the indexed timer heap: sequencer, position map and result register
// usage
// - req carries one operation item: add, adjust expiry, delete or tick
// - rsp carries result items; last marks the final one of an operation
// - add, adjust and delete give exactly one result; a tick gives one result per
//   expired timer in pop order, or a single none-due result
// - req.ready is high only while the sequencer is idle, one operation at a time
// - heap slots live in a ram with a registered read port, handle positions in a
//   second ram; a flop per handle marks presence, so reset needs no clearing pass
// operation
// - a sift-down level reads the left, then the right child, and moves the smaller
//   one up if it beats the moving entry; a sift-up level reads the parent; adjust
//   and delete add a position lookup, every operation a root read, and a tick does
//   this again per popped timer; at most one heap slot is read per cycle
// reset
// - heap is empty, all handles absent, no result pending
// stall
// - a finished result sits in the output register; the next request is taken
//   while it waits; a later result, also the next one of a tick, stops until rsp
//   takes the waiting one
`include "indexed_timer_min_heap_core_assert.svh"

module indexed_timer_min_heap_core #(
    parameter int CAPACITY   = 64,
    parameter int TIME_WIDTH = 48
) (
    input  logic       clk,
    input  logic       rst_n,
    itmh_in_if.sink    req,
    itmh_out_if.source rsp
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = AW + 2;
    localparam int HW = itmh_pkg::HANDLE_W;
    localparam int EW = HW + TIME_WIDTH;

    // sequencer state
    itmh_pkg::state_t  state_reg, state_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [itmh_pkg::NUM_HANDLES-1:0] vld_reg, vld_next;
    logic              popped_any_reg, popped_any_next;

    // working registers of the current operation
    itmh_pkg::op_t     op_reg, op_next;
    itmh_pkg::status_t st_reg, st_next;
    logic [HW-1:0]         h_reg, h_next;
    logic [TIME_WIDTH-1:0] ek_reg, ek_next;
    logic [TIME_WIDTH-1:0] now_reg, now_next;
    logic [AW-1:0]         i_reg, i_next;
    logic [HW-1:0]         xh_reg, xh_next;
    logic [TIME_WIDTH-1:0] xk_reg, xk_next;
    logic [HW-1:0]         bh_reg, bh_next;
    logic [TIME_WIDTH-1:0] bk_reg, bk_next;
    logic [AW-1:0]         bidx_reg, bidx_next;
    logic                  bmv_reg, bmv_next;
    logic [HW-1:0]         popped_h_reg, popped_h_next;

    // output register
    logic                      ov_reg;
    itmh_pkg::status_t         o_status_reg;
    logic [HW-1:0]             o_handle_reg;
    logic                      o_last_reg;
    logic [TIME_WIDTH-1:0]     o_top_reg;
    logic                      o_empty_reg;
    logic [CW-1:0]             o_cnt_reg;

    // memory ports
    logic          h_we, h_re;
    logic [AW-1:0] h_waddr, h_raddr;
    logic [EW-1:0] h_wdata, h_rdata;
    logic          p_we, p_re;
    logic [HW-1:0] p_waddr, p_raddr;
    logic [AW-1:0] p_wdata, p_rdata;

    // result emission
    logic              emit;
    itmh_pkg::status_t e_status;
    logic [HW-1:0]     e_handle;
    logic              e_last;
    logic              slot_free;

    logic                  accept;
    logic [HW-1:0]         rd_h;
    logic [TIME_WIDTH-1:0] rd_k;
    logic [XW-1:0]         l_x, r_x, cnt_x;
    logic [AW-1:0]         pm1, par;
    logic [CW-1:0]         cm1;
    logic                  due, need;
    logic [TIME_WIDTH-1:0] cmpk;

    // heap slots: {handle, expiry}
    itmh_ram #(.W(EW), .DEPTH(CAPACITY)) u_heap (
        .clk   (clk),
        .we    (h_we),
        .waddr (h_waddr),
        .wdata (h_wdata),
        .re    (h_re),
        .raddr (h_raddr),
        .rdata (h_rdata)
    );

    // slot of each handle
    itmh_ram #(.W(AW), .DEPTH(itmh_pkg::NUM_HANDLES)) u_pos (
        .clk   (clk),
        .we    (p_we),
        .waddr (p_waddr),
        .wdata (p_wdata),
        .re    (p_re),
        .raddr (p_raddr),
        .rdata (p_rdata)
    );

    assign rd_h  = h_rdata[EW-1:TIME_WIDTH];
    assign rd_k  = h_rdata[TIME_WIDTH-1:0];
    assign cnt_x = XW'(cnt_reg);
    // children of the hole: 2i+1 and 2i+2
    assign l_x   = {1'b0, i_reg, 1'b1};
    assign r_x   = l_x + XW'(1);
    // parent of the hole: (i-1)/2
    assign pm1   = i_reg - AW'(1);
    assign par   = pm1 >> 1;
    assign cm1   = cnt_reg - CW'(1);

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == itmh_pkg::S_IDLE);
    assign slot_free = !ov_reg || rsp.ready;

    // root is due on a tick when present and not later than now
    assign due  = (op_reg == itmh_pkg::OP_TICK) && (cnt_reg != '0) && (rd_k <= now_reg);
    // a result must go out at the root check unless this is the first pop of a tick
    assign need = (op_reg != itmh_pkg::OP_TICK) || popped_any_reg || !due;

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        vld_next        = vld_reg;
        popped_any_next = popped_any_reg;
        op_next         = op_reg;
        st_next         = st_reg;
        h_next          = h_reg;
        ek_next         = ek_reg;
        now_next        = now_reg;
        i_next          = i_reg;
        xh_next         = xh_reg;
        xk_next         = xk_reg;
        bh_next         = bh_reg;
        bk_next         = bk_reg;
        bidx_next       = bidx_reg;
        bmv_next        = bmv_reg;
        popped_h_next   = popped_h_reg;

        h_we    = 1'b0;
        h_waddr = i_reg;
        h_wdata = {xh_reg, xk_reg};
        h_re    = 1'b0;
        h_raddr = '0;
        p_we    = 1'b0;
        p_waddr = xh_reg;
        p_wdata = i_reg;
        p_re    = 1'b0;
        p_raddr = req.timer_handle;

        emit     = 1'b0;
        e_status = st_reg;
        e_handle = '0;
        e_last   = 1'b1;
        cmpk     = bmv_reg ? bk_reg : xk_reg;

        unique case (state_reg)
            itmh_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    op_next  = itmh_pkg::op_t'(req.op);
                    h_next   = req.timer_handle;
                    ek_next  = req.expire_time;
                    now_next = req.now_time;
                    st_next  = itmh_pkg::ST_DONE;
                    unique case (itmh_pkg::op_t'(req.op))
                        itmh_pkg::OP_ADD:
                        begin
                            if (vld_reg[req.timer_handle])
                            begin
                                st_next    = itmh_pkg::ST_IN_USE;
                                state_next = itmh_pkg::S_FIN;
                            end
                            else if (cnt_reg >= CW'(CAPACITY))
                            begin
                                st_next    = itmh_pkg::ST_FULL;
                                state_next = itmh_pkg::S_FIN;
                            end
                            else
                            begin
                                vld_next[req.timer_handle] = 1'b1;
                                cnt_next   = cnt_reg + CW'(1);
                                i_next     = cnt_reg[AW-1:0];
                                xh_next    = req.timer_handle;
                                xk_next    = req.expire_time;
                                state_next = itmh_pkg::S_SD;
                            end
                        end
                        itmh_pkg::OP_ADJUST,
                        itmh_pkg::OP_DELETE:
                        begin
                            if (!vld_reg[req.timer_handle])
                            begin
                                st_next    = itmh_pkg::ST_ABSENT;
                                state_next = itmh_pkg::S_FIN;
                            end
                            else
                            begin
                                p_re       = 1'b1;
                                state_next = itmh_pkg::S_LOOK;
                            end
                        end
                        itmh_pkg::OP_TICK:
                        begin
                            popped_any_next = 1'b0;
                            state_next      = itmh_pkg::S_FIN;
                        end
                        default:
                        begin
                            state_next = itmh_pkg::S_FIN;
                        end
                    endcase
                end
            end

            itmh_pkg::S_LOOK:
            begin
                i_next = p_rdata;
                if (op_reg == itmh_pkg::OP_ADJUST)
                begin
                    xh_next    = h_reg;
                    xk_next    = ek_reg;
                    state_next = itmh_pkg::S_SD;
                end
                else
                begin
                    // delete: last slot fills the hole
                    vld_next[h_reg] = 1'b0;
                    cnt_next        = cm1;
                    if (p_rdata == cm1[AW-1:0])
                    begin
                        state_next = itmh_pkg::S_FIN;
                    end
                    else
                    begin
                        h_re       = 1'b1;
                        h_raddr    = cm1[AW-1:0];
                        state_next = itmh_pkg::S_LAST;
                    end
                end
            end

            itmh_pkg::S_LAST:
            begin
                xh_next    = rd_h;
                xk_next    = rd_k;
                state_next = itmh_pkg::S_SD;
            end

            itmh_pkg::S_SD:
            begin
                if (l_x < cnt_x)
                begin
                    h_re       = 1'b1;
                    h_raddr    = l_x[AW-1:0];
                    state_next = itmh_pkg::S_DNL;
                end
                else
                begin
                    state_next = itmh_pkg::S_SU;
                end
            end

            itmh_pkg::S_DNL:
            begin
                // left child only wins when strictly smaller
                if (rd_k < xk_reg)
                begin
                    bk_next   = rd_k;
                    bh_next   = rd_h;
                    bidx_next = l_x[AW-1:0];
                    bmv_next  = 1'b1;
                end
                else
                begin
                    bmv_next = 1'b0;
                end
                if (r_x < cnt_x)
                begin
                    h_re       = 1'b1;
                    h_raddr    = r_x[AW-1:0];
                    state_next = itmh_pkg::S_DNR;
                end
                else
                begin
                    state_next = itmh_pkg::S_DMV;
                end
            end

            itmh_pkg::S_DNR:
            begin
                if (rd_k < cmpk)
                begin
                    bk_next   = rd_k;
                    bh_next   = rd_h;
                    bidx_next = r_x[AW-1:0];
                    bmv_next  = 1'b1;
                end
                state_next = itmh_pkg::S_DMV;
            end

            itmh_pkg::S_DMV:
            begin
                if (bmv_reg)
                begin
                    // child moves up into the hole
                    h_we       = 1'b1;
                    h_wdata    = {bh_reg, bk_reg};
                    p_we       = 1'b1;
                    p_waddr    = bh_reg;
                    i_next     = bidx_reg;
                    state_next = itmh_pkg::S_SD;
                end
                else
                begin
                    state_next = itmh_pkg::S_SU;
                end
            end

            itmh_pkg::S_SU:
            begin
                if (i_reg == '0)
                begin
                    h_we       = 1'b1;
                    p_we       = 1'b1;
                    state_next = itmh_pkg::S_FIN;
                end
                else
                begin
                    h_re       = 1'b1;
                    h_raddr    = par;
                    state_next = itmh_pkg::S_UPW;
                end
            end

            itmh_pkg::S_UPW:
            begin
                if (rd_k <= xk_reg)
                begin
                    // equal keys stop the climb
                    h_we       = 1'b1;
                    p_we       = 1'b1;
                    state_next = itmh_pkg::S_FIN;
                end
                else
                begin
                    h_we       = 1'b1;
                    h_wdata    = h_rdata;
                    p_we       = 1'b1;
                    p_waddr    = rd_h;
                    i_next     = par;
                    state_next = itmh_pkg::S_SU;
                end
            end

            itmh_pkg::S_FIN:
            begin
                h_re       = (cnt_reg != '0);
                h_raddr    = '0;
                state_next = itmh_pkg::S_ROOT;
            end

            itmh_pkg::S_ROOT:
            begin
                if (!(need && !slot_free))
                begin
                    if (need)
                    begin
                        emit = 1'b1;
                        if (op_reg != itmh_pkg::OP_TICK)
                        begin
                            e_status = st_reg;
                            e_last   = 1'b1;
                        end
                        else if (popped_any_reg)
                        begin
                            e_status = itmh_pkg::ST_EXPIRED;
                            e_handle = popped_h_reg;
                            e_last   = !due;
                        end
                        else
                        begin
                            e_status = itmh_pkg::ST_NONE_DUE;
                            e_last   = 1'b1;
                        end
                    end
                    if (due)
                    begin
                        popped_h_next   = rd_h;
                        popped_any_next = 1'b1;
                        vld_next[rd_h]  = 1'b0;
                        cnt_next        = cm1;
                        i_next          = '0;
                        if (cm1 != '0)
                        begin
                            h_re       = 1'b1;
                            h_raddr    = cm1[AW-1:0];
                            state_next = itmh_pkg::S_LAST;
                        end
                        else
                        begin
                            state_next = itmh_pkg::S_FIN;
                        end
                    end
                    else
                    begin
                        state_next = itmh_pkg::S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = itmh_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= itmh_pkg::S_IDLE;
            cnt_reg        <= '0;
            vld_reg        <= '0;
            popped_any_reg <= 1'b0;
            ov_reg         <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            vld_reg        <= vld_next;
            popped_any_reg <= popped_any_next;
            if (emit)
            begin
                ov_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        st_reg       <= st_next;
        h_reg        <= h_next;
        ek_reg       <= ek_next;
        now_reg      <= now_next;
        i_reg        <= i_next;
        xh_reg       <= xh_next;
        xk_reg       <= xk_next;
        bh_reg       <= bh_next;
        bk_reg       <= bk_next;
        bidx_reg     <= bidx_next;
        bmv_reg      <= bmv_next;
        popped_h_reg <= popped_h_next;
        if (emit)
        begin
            o_status_reg <= e_status;
            o_handle_reg <= e_handle;
            o_last_reg   <= e_last;
            o_top_reg    <= (cnt_reg != '0) ? rd_k : '0;
            o_empty_reg  <= (cnt_reg == '0);
            o_cnt_reg    <= cnt_reg;
        end
    end

    assign rsp.valid          = ov_reg;
    assign rsp.status         = o_status_reg;
    assign rsp.expired_handle = o_handle_reg;
    assign rsp.last           = o_last_reg;
    assign rsp.root_expiry    = o_top_reg;
    assign rsp.heap_empty     = o_empty_reg;
    assign rsp.timer_count    = o_cnt_reg;

    // checks
    `ITMH_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_reg <= CW'(CAPACITY), "entry count above capacity")
    `ITMH_ASSERT_IMP(a_present_match, 1'b1, $countones(vld_reg) == 32'(cnt_reg), "presence flags disagree with count")
    `ITMH_ASSERT_IMP(a_emit_slot, emit, slot_free, "result written over a waiting one")
    `ITMH_ASSERT_NXT(a_add_count, accept && req.op == itmh_pkg::OP_ADD && !vld_reg[req.timer_handle] && cnt_reg < CW'(CAPACITY), cnt_reg == $past(cnt_reg) + CW'(1), "add did not grow the heap")

endmodule
